/* hdl/gfa_pkg.sv */
`default_nettype none
package gfa_pkg;

  localparam int unsigned SqrtW  = 33;
  localparam int unsigned QuotW  = 33;
  localparam int unsigned EpsRaw = 6553;

  localparam logic [30:0] StopSpeedRst = 31'd6553600;
  localparam logic [23:0] FrictionRst  = 24'd393216;
  localparam logic [23:0] AccelRst     = 24'd655360;
  localparam logic [15:0] TickRst      = 16'd1092;

  typedef enum logic [1:0] {
    RegStopSpeed = 2'd0,
    RegFriction  = 2'd1,
    RegAccel     = 2'd2,
    RegTick      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               has_input;
    logic signed [15:0] wish_dir_x;
    logic signed [15:0] wish_dir_y;
    logic [30:0]        wish_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_word_t;

  typedef struct packed {
    logic [30:0] stop_speed;
    logic [23:0] friction_amount;
    logic [23:0] ground_accel;
    logic [15:0] tick_time;
  } cfg_t;

endpackage
`default_nettype wire

/* hdl/ground_friction_accelerate.sv */
`default_nettype none
// Fully pipelined ground friction and acceleration: one word may start every
// cycle and busy_o is always low. Each result appears on done_o after the
// registered stages for magnitudes, squares and their sum, 33 square root
// steps, the friction drop and the rescale products, 66 divide steps for the
// rescale, and projection, acceleration and saturation. The result is shown
// for one cycle only; the receiver cannot stall the pipeline.
module ground_friction_accelerate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire gfa_pkg::in_word_t  in_word_i,
  output logic                    done_o,
  output gfa_pkg::out_word_t      out_word_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gfa_pkg::*;

  localparam int unsigned PayW  = $bits(in_word_t);
  localparam int unsigned SqN   = SqrtW;
  localparam int unsigned DivN  = 2 * QuotW;

  cfg_t cfg;

  gfa_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg_o(cfg)
  );
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  // s1: magnitudes
  logic      v1_q;
  in_word_t  p1_q;
  logic [31:0] ax1_q, ay1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    p1_q  <= in_word_i;
    ax1_q <= in_word_i.vel_x[31] ? 32'(-in_word_i.vel_x) : in_word_i.vel_x;
    ay1_q <= in_word_i.vel_y[31] ? 32'(-in_word_i.vel_y) : in_word_i.vel_y;
  end

  // s2: squares
  logic      v2_q;
  in_word_t  p2_q;
  logic [63:0] sx2_q, sy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    p2_q  <= p1_q;
    sx2_q <= ax1_q * ax1_q;
    sy2_q <= ay1_q * ay1_q;
  end

  // s3: sum
  logic      v3_q;
  in_word_t  p3_q;
  logic [65:0] sum3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    p3_q   <= p2_q;
    sum3_q <= {2'b00, sx2_q} + {2'b00, sy2_q};
  end

  // square root chain
  logic             sv  [SqN+1];
  logic [65:0]      srem[SqN+1];
  logic [32:0]      sroot[SqN+1];
  logic [65:0]      ssrc[SqN+1];
  logic [PayW-1:0]  spay[SqN+1];
  assign sv[0]    = v3_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign ssrc[0]  = sum3_q;
  assign spay[0]  = p3_q;

  for (genvar g = 0; g < SqN; g++) begin : g_sqrt
    gfa_sqrt_stage #(.Step(g), .PayW(PayW)) u_st (
      .clk_i, .rst_ni,
      .vld_i(sv[g]), .rem_i(srem[g]), .root_i(sroot[g]), .src_i(ssrc[g]),
      .pay_i(spay[g]),
      .vld_o(sv[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1]),
      .src_o(ssrc[g+1]), .pay_o(spay[g+1])
    );
  end

  in_word_t    pq;
  logic [32:0] speed;
  assign pq    = in_word_t'(spay[SqN]);
  assign speed = sroot[SqN];

  // f1: control * friction
  logic      f1v_q;
  in_word_t  f1p_q;
  logic [32:0] f1s_q;
  logic [56:0] f1m_q;
  logic [32:0] ctrl;
  assign ctrl = (speed > {2'b00, cfg.stop_speed}) ? speed : {2'b00, cfg.stop_speed};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1v_q <= 1'b0;
    else f1v_q <= sv[SqN];
  end
  always_ff @(posedge clk_i) begin
    f1p_q <= pq;
    f1s_q <= speed;
    f1m_q <= ctrl * cfg.friction_amount;
  end

  // f2: * tick
  logic      f2v_q;
  in_word_t  f2p_q;
  logic [32:0] f2s_q;
  logic [56:0] f2m_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f2v_q <= 1'b0;
    else f2v_q <= f1v_q;
  end
  always_ff @(posedge clk_i) begin
    f2p_q <= f1p_q;
    f2s_q <= f1s_q;
    f2m_q <= f1m_q[56:16] * cfg.tick_time;
  end

  // f3: new speed and numerators
  logic      f3v_q;
  in_word_t  f3p_q;
  logic [32:0] f3s_q, f3n_q;
  logic        f3slow_q;
  logic [40:0] drop;
  logic [32:0] ns;
  assign drop = f2m_q[56:16];
  assign ns   = (drop >= {8'd0, f2s_q}) ? '0 : 33'({8'd0, f2s_q} - drop);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f3v_q <= 1'b0;
    else f3v_q <= f2v_q;
  end
  always_ff @(posedge clk_i) begin
    f3p_q    <= f2p_q;
    f3s_q    <= f2s_q;
    f3n_q    <= ns;
    f3slow_q <= f2s_q <= 33'(EpsRaw);
  end

  // f4: magnitude products
  logic      f4v_q;
  in_word_t  f4p_q;
  logic [32:0] f4s_q, f4n_q;
  logic        f4slow_q;
  logic [65:0] f4mx_q, f4my_q;
  logic [31:0] mx, my;
  assign mx = f3p_q.vel_x[31] ? 32'(-f3p_q.vel_x) : f3p_q.vel_x;
  assign my = f3p_q.vel_y[31] ? 32'(-f3p_q.vel_y) : f3p_q.vel_y;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f4v_q <= 1'b0;
    else f4v_q <= f3v_q;
  end
  always_ff @(posedge clk_i) begin
    f4p_q    <= f3p_q;
    f4s_q    <= f3s_q;
    f4n_q    <= f3n_q;
    f4slow_q <= f3slow_q;
    f4mx_q   <= 66'(mx * f3n_q);
    f4my_q   <= 66'(my * f3n_q);
  end

  // divider payload: word, new speed equals speed, slow flag
  localparam int unsigned DPayW = PayW + 2;
  logic             dv  [DivN+1];
  logic [65:0]      dnx [DivN+1];
  logic [65:0]      dny [DivN+1];
  logic [33:0]      drx [DivN+1];
  logic [33:0]      dry [DivN+1];
  logic [32:0]      dden[DivN+1];
  logic [DPayW-1:0] dpay[DivN+1];
  assign dv[0]   = f4v_q;
  assign dnx[0]  = f4mx_q;
  assign dny[0]  = f4my_q;
  assign drx[0]  = '0;
  assign dry[0]  = '0;
  assign dden[0] = f4s_q;
  assign dpay[0] = {f4p_q, f4n_q == f4s_q, f4slow_q};

  for (genvar g = 0; g < DivN; g++) begin : g_div
    gfa_div_stage #(.Step(g), .PayW(DPayW)) u_st (
      .clk_i, .rst_ni,
      .vld_i(dv[g]), .num_x_i(dnx[g]), .num_y_i(dny[g]),
      .rem_x_i(drx[g]), .rem_y_i(dry[g]), .den_i(dden[g]), .pay_i(dpay[g]),
      .vld_o(dv[g+1]), .num_x_o(dnx[g+1]), .num_y_o(dny[g+1]),
      .rem_x_o(drx[g+1]), .rem_y_o(dry[g+1]), .den_o(dden[g+1]),
      .pay_o(dpay[g+1])
    );
  end

  // a1: friction result
  in_word_t dp;
  logic     dsame, dslow;
  assign {dp, dsame, dslow} = dpay[DivN];
  logic      a1v_q;
  in_word_t  a1p_q;
  logic signed [33:0] a1x_q, a1y_q;
  logic signed [33:0] qx, qy;
  assign qx = dp.vel_x[31] ? -$signed({1'b0, dnx[DivN][32:0]})
                           : $signed({1'b0, dnx[DivN][32:0]});
  assign qy = dp.vel_y[31] ? -$signed({1'b0, dny[DivN][32:0]})
                           : $signed({1'b0, dny[DivN][32:0]});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a1v_q <= 1'b0;
    else a1v_q <= dv[DivN];
  end
  always_ff @(posedge clk_i) begin
    a1p_q <= dp;
    if (dslow) begin
      a1x_q <= '0;
      a1y_q <= '0;
    end else if (dsame) begin
      a1x_q <= 34'(dp.vel_x);
      a1y_q <= 34'(dp.vel_y);
    end else begin
      a1x_q <= qx;
      a1y_q <= qy;
    end
  end

  // a2: dot products, accel cap product
  logic      a2v_q;
  in_word_t  a2p_q;
  logic signed [33:0] a2x_q, a2y_q;
  logic signed [49:0] a2px_q, a2py_q;
  logic [54:0] a2c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a2v_q <= 1'b0;
    else a2v_q <= a1v_q;
  end
  always_ff @(posedge clk_i) begin
    a2p_q  <= a1p_q;
    a2x_q  <= a1x_q;
    a2y_q  <= a1y_q;
    a2px_q <= a1x_q * 50'(a1p_q.wish_dir_x);
    a2py_q <= a1y_q * 50'(a1p_q.wish_dir_y);
    a2c_q  <= a1p_q.wish_speed * cfg.ground_accel;
  end

  // a3: shortfall, cap * tick
  logic      a3v_q;
  in_word_t  a3p_q;
  logic signed [33:0] a3x_q, a3y_q;
  logic signed [51:0] a3add_q;
  logic [54:0] a3c_q;
  logic signed [50:0] dot;
  assign dot = 51'(a2px_q) + 51'(a2py_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a3v_q <= 1'b0;
    else a3v_q <= a2v_q;
  end
  always_ff @(posedge clk_i) begin
    a3p_q   <= a2p_q;
    a3x_q   <= a2x_q;
    a3y_q   <= a2y_q;
    a3add_q <= $signed({21'd0, a2p_q.wish_speed}) - 52'(dot >>> 14);
    a3c_q   <= 55'(a2c_q[54:16] * cfg.tick_time);
  end

  // a4: increments
  logic      a4v_q;
  logic signed [33:0] a4x_q, a4y_q;
  logic signed [50:0] a4ix_q, a4iy_q;
  logic        a4en_q;
  logic [34:0] acc;
  assign acc = ({13'd0, a3add_q[50:0]} > 64'(a3c_q[54:16])) ? 35'(a3c_q[54:16])
             : 35'(a3add_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a4v_q <= 1'b0;
    else a4v_q <= a3v_q;
  end
  always_ff @(posedge clk_i) begin
    a4x_q  <= a3x_q;
    a4y_q  <= a3y_q;
    a4en_q <= a3p_q.has_input && !a3add_q[51] && a3add_q != '0;
    a4ix_q <= a3p_q.wish_dir_x * $signed({1'b0, acc});
    a4iy_q <= a3p_q.wish_dir_y * $signed({1'b0, acc});
  end

  // a5: add and saturate
  logic      a5v_q;
  out_word_t a5o_q;
  logic signed [37:0] rx, ry;
  assign rx = a4en_q ? 38'(a4x_q) + 38'(a4ix_q >>> 14) : 38'(a4x_q);
  assign ry = a4en_q ? 38'(a4y_q) + 38'(a4iy_q >>> 14) : 38'(a4y_q);

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sh007FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -38'sh0080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a5v_q <= 1'b0;
    else a5v_q <= a4v_q;
  end
  always_ff @(posedge clk_i) begin
    a5o_q.new_vel_x <= sat32(rx);
    a5o_q.new_vel_y <= sat32(ry);
  end

  assign done_o     = a5v_q;
  assign out_word_o = a5o_q;
endmodule
`default_nettype wire

/* hdl/gfa_regs.sv */
`default_nettype none
module gfa_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output gfa_pkg::cfg_t    cfg_o
);
  import gfa_pkg::*;

  cfg_t cfg_q;
  logic wr;
  reg_idx_e idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_speed      <= StopSpeedRst;
      cfg_q.friction_amount <= FrictionRst;
      cfg_q.ground_accel    <= AccelRst;
      cfg_q.tick_time       <= TickRst;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        RegStopSpeed: cfg_q.stop_speed      <= pwdata[30:0];
        RegFriction:  cfg_q.friction_amount <= pwdata[23:0];
        RegAccel:     cfg_q.ground_accel    <= pwdata[23:0];
        RegTick:      cfg_q.tick_time       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegStopSpeed: prdata = {1'b0, cfg_q.stop_speed};
      RegFriction:  prdata = {8'd0, cfg_q.friction_amount};
      RegAccel:     prdata = {8'd0, cfg_q.ground_accel};
      RegTick:      prdata = {16'd0, cfg_q.tick_time};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

/* hdl/gfa_sqrt_stage.sv */
`default_nettype none
// one restoring square root step per stage, one result bit per step from two radicand bits
module gfa_sqrt_stage #(
  parameter int unsigned Step = 0,
  parameter int unsigned PayW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire logic [65:0]     rem_i,
  input  wire logic [32:0]     root_i,
  input  wire logic [65:0]     src_i,
  input  wire logic [PayW-1:0] pay_i,
  output logic                 vld_o,
  output logic [65:0]          rem_o,
  output logic [32:0]          root_o,
  output logic [65:0]          src_o,
  output logic [PayW-1:0]      pay_o
);
  localparam int unsigned Sh = 64 - 2 * Step;

  logic [67:0] rem_d;
  logic [67:0] trial;
  logic        vld_q;
  logic [65:0] rem_q;
  logic [32:0] root_q;
  logic [65:0] src_q;
  logic [PayW-1:0] pay_q;

  always_comb begin
    rem_d = {rem_i, 2'b00} | {66'd0, src_i[Sh +: 2]};
    trial = {33'd0, root_i, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_i;
    pay_q <= pay_i;
    if (rem_d >= trial) begin
      rem_q  <= 66'(rem_d - trial);
      root_q <= {root_i[31:0], 1'b1};
    end else begin
      rem_q  <= rem_d[65:0];
      root_q <= {root_i[31:0], 1'b0};
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign src_o  = src_q;
  assign pay_o  = pay_q;
endmodule
`default_nettype wire

/* hdl/gfa_div_stage.sv */
`default_nettype none
// one restoring divide step per stage for both components
module gfa_div_stage #(
  parameter int unsigned Step = 0,
  parameter int unsigned PayW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire logic [65:0]     num_x_i,
  input  wire logic [65:0]     num_y_i,
  input  wire logic [33:0]     rem_x_i,
  input  wire logic [33:0]     rem_y_i,
  input  wire logic [32:0]     den_i,
  input  wire logic [PayW-1:0] pay_i,
  output logic                 vld_o,
  output logic [65:0]          num_x_o,
  output logic [65:0]          num_y_o,
  output logic [33:0]          rem_x_o,
  output logic [33:0]          rem_y_o,
  output logic [32:0]          den_o,
  output logic [PayW-1:0]      pay_o
);
  localparam int unsigned Bit = 65 - Step;

  logic [34:0] tx, ty;
  logic        qbx, qby;
  logic [65:0] nx_d, ny_d;
  logic [33:0] rx_d, ry_d;
  logic        vld_q;
  logic [65:0] nx_q, ny_q;
  logic [33:0] rx_q, ry_q;
  logic [32:0] den_q;
  logic [PayW-1:0] pay_q;

  assign tx  = {rem_x_i, num_x_i[Bit]};
  assign ty  = {rem_y_i, num_y_i[Bit]};
  assign qbx = tx >= {2'b00, den_i};
  assign qby = ty >= {2'b00, den_i};

  always_comb begin
    nx_d      = num_x_i;
    ny_d      = num_y_i;
    nx_d[Bit] = qbx;
    ny_d[Bit] = qby;
    rx_d      = qbx ? 34'(tx - {2'b00, den_i}) : tx[33:0];
    ry_d      = qby ? 34'(ty - {2'b00, den_i}) : ty[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    pay_q <= pay_i;
    nx_q  <= nx_d;
    ny_q  <= ny_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
  end

  assign vld_o   = vld_q;
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;
  assign rem_x_o = rx_q;
  assign rem_y_o = ry_q;
  assign den_o   = den_q;
  assign pay_o   = pay_q;
endmodule
`default_nettype wire

/* hdl/gfa_checker.sv */
`default_nettype none
module gfa_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pready
);
  localparam int unsigned Lat = 111;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !penable |=> psel && penable) else $error("apb access missing");
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !done_o || !$past(!rst_ni))
    else $error("done during reset");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat)) else $error("done without start");
endmodule

bind ground_friction_accelerate gfa_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .psel, .penable, .pready
);
`default_nettype wire
